@@ rtl/pws_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, command and status types for the wavetable synth
// no dependencies
package pws_pkg;

	localparam int unsigned TABLE_SIZE   = 48000;
	localparam int unsigned VOICES       = 8;
	localparam int unsigned SINE_PEAK    = 8388607;
	localparam int unsigned MAX_VOLUME   = 15;
	localparam int unsigned COUNTER_WRAP = 48000;
	localparam int unsigned DIV_STEPS    = 28;

	localparam logic [7:0] BREAK_CODE    = 8'hF0;
	localparam logic [7:0] VOL_UP_CODE   = 8'h49;
	localparam logic [7:0] VOL_DOWN_CODE = 8'h41;

	localparam logic [7:0] KEY_CODES [8] = '{8'h1C, 8'h1B, 8'h23, 8'h2B,
		8'h3B, 8'h42, 8'h4B, 8'h4C};

	localparam logic [30:0] STEP_RESET [8] = '{31'd8572961, 31'd9622782,
		31'd10801250, 31'd11443503, 31'd12844925, 31'd14417920,
		31'd16183591, 31'd17145922};

	// sine polynomial, q30, horner order after the top term
	localparam logic [30:0] COEF_TOP = 31'd61;
	localparam logic [30:0] HORNER_COEF [6] = '{31'd3864, 31'd172272, 31'd5026995,
		31'd85569307, 31'd693598668, 31'd1686629713};

	// table position p = i * 2^32 / TABLE_SIZE split as integer and remainder parts
	localparam longint unsigned TWO_32      = 64'd1 << 32;
	localparam longint unsigned P_INT       = TWO_32 / TABLE_SIZE;
	localparam longint unsigned P_REM       = TWO_32 % TABLE_SIZE;
	localparam int unsigned     RECIP_SHIFT = 40;
	localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / TABLE_SIZE;
	localparam longint unsigned PHASE_MOD   = 64'(TABLE_SIZE) * 64'd65536;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_SCAN,
		CMD_START,
		CMD_IDX,
		CMD_P_INT,
		CMD_P_REM,
		CMD_Y_MUL,
		CMD_Q0_MUL,
		CMD_P_FIX,
		CMD_U,
		CMD_UU,
		CMD_H_INIT,
		CMD_H_MUL,
		CMD_H_SUB,
		CMD_S_MUL,
		CMD_PK_MUL,
		CMD_MAG,
		CMD_W_MUL,
		CMD_ACC,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_GAIN_MUL,
		CMD_OUT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [2:0] voice;
		logic       entry;
		logic [2:0] coef;
	} dp_cmd_t;

	typedef struct packed {
		logic [7:0] notes;
		logic       out_free;
	} dp_status_t;

endpackage

@@ rtl/pws_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the synth: walks voices, table entries and the divider
// depends on pws_pkg
module pws_ctrl import pws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       op,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOICE,
		ST_ENTRY,
		ST_DIV_INIT,
		ST_DIV,
		ST_GAIN,
		ST_OUT
	} state_t;

	localparam logic [4:0] STEP_H_FIRST = 5'd9;
	localparam logic [4:0] STEP_H_LAST  = 5'd20;
	localparam logic [4:0] STEP_LAST    = 5'd25;

	state_t     state_q;
	logic [3:0] voice_q;
	logic       entry_q;
	logic [4:0] step_q;
	logic [4:0] div_q;
	logic [4:0] coef_off;

	assign in_ready = (state_q == ST_IDLE);
	assign coef_off = (step_q - 5'd10) >> 1;

	always_comb begin
		cmd.op    = CMD_NONE;
		cmd.voice = voice_q[2:0];
		cmd.entry = entry_q;
		cmd.coef  = coef_off[2:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = op ? CMD_START : CMD_SCAN;
				end
			end
			ST_ENTRY: begin
				case (step_q) inside
					5'd0:  cmd.op = CMD_IDX;
					5'd1:  cmd.op = CMD_P_INT;
					5'd2:  cmd.op = CMD_P_REM;
					5'd3:  cmd.op = CMD_Y_MUL;
					5'd4:  cmd.op = CMD_Q0_MUL;
					5'd5:  cmd.op = CMD_P_FIX;
					5'd6:  cmd.op = CMD_U;
					5'd7:  cmd.op = CMD_UU;
					5'd8:  cmd.op = CMD_H_INIT;
					[STEP_H_FIRST:STEP_H_LAST]: cmd.op = step_q[0] ? CMD_H_MUL : CMD_H_SUB;
					5'd21: cmd.op = CMD_S_MUL;
					5'd22: cmd.op = CMD_PK_MUL;
					5'd23: cmd.op = CMD_MAG;
					5'd24: cmd.op = CMD_W_MUL;
					5'd25: cmd.op = CMD_ACC;
					default: cmd.op = CMD_NONE;
				endcase
			end
			ST_DIV_INIT: cmd.op = CMD_DIV_INIT;
			ST_DIV:      cmd.op = CMD_DIV_STEP;
			ST_GAIN:     cmd.op = CMD_GAIN_MUL;
			ST_OUT: begin
				if (status.out_free) begin
					cmd.op = CMD_OUT;
				end
			end
			default: cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			voice_q <= '0;
			entry_q <= 1'b0;
			step_q  <= '0;
			div_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && op) begin
						voice_q <= '0;
						state_q <= ST_VOICE;
					end
				end
				ST_VOICE: begin
					if (voice_q == 4'(VOICES)) begin
						state_q <= ST_DIV_INIT;
					end else if (status.notes[voice_q[2:0]]) begin
						entry_q <= 1'b0;
						step_q  <= '0;
						state_q <= ST_ENTRY;
					end else begin
						voice_q <= voice_q + 4'd1;
					end
				end
				ST_ENTRY: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (entry_q) begin
							voice_q <= voice_q + 4'd1;
							state_q <= ST_VOICE;
						end else begin
							entry_q <= 1'b1;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DIV_INIT: begin
					div_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_q == 5'(DIV_STEPS - 1)) begin
						state_q <= ST_GAIN;
					end else begin
						div_q <= div_q + 5'd1;
					end
				end
				ST_GAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/pws_dp.sv @@
`timescale 1ns / 1ps
// datapath: voice state, sine evaluation, interpolation, mix divider, output register
// depends on pws_pkg
module pws_dp import pws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic [7:0]         scan_code,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] sample,
	output logic [7:0]         active_notes
);

	logic [30:0] step_q [8];
	logic [31:0] phase_q [8];
	logic [15:0] counter_q;
	logic [7:0]  notes_q;
	logic        rel_q;
	logic [3:0]  gain_q;

	logic [15:0]        i_q;
	logic [31:0]        pa_q;
	logic [30:0]        y_q;
	logic [15:0]        q0_q;
	logic [31:0]        p_q;
	logic [1:0]         quad_q;
	logic [30:0]        u_q;
	logic [30:0]        u2_q;
	logic [30:0]        t_q;
	logic [22:0]        mag_q;
	logic               neg_q;
	logic signed [43:0] acc_q;
	logic [27:0]        num_q;
	logic [3:0]         rem_q;
	logic               dsgn_q;
	logic [3:0]         n_q;
	logic [63:0]        prod_q;

	logic               out_valid_q;
	logic signed [23:0] sample_q;
	logic [7:0]         notes_out_q;

	logic [31:0] mul_a, mul_b;
	logic [31:0] cur_phase;
	logic [15:0] idx_cur, idx_inc;
	logic [16:0] weight;
	logic [31:0] rem_chk;
	logic [24:0] mag_rnd;
	logic [43:0] acc_abs;
	logic [4:0]  trial;
	logic [31:0] t_new;
	logic [31:0] gain_mag;
	logic        hit;
	logic [2:0]  hit_k;

	assign status.notes    = notes_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample          = sample_q;
	assign active_notes    = notes_out_q;

	assign cur_phase = phase_q[cmd.voice];
	assign idx_cur   = cur_phase[31:16];
	assign idx_inc   = (idx_cur + 16'd1 == 16'(TABLE_SIZE)) ? 16'd0 : idx_cur + 16'd1;
	assign weight    = cmd.entry ? {1'b0, cur_phase[15:0]} : 17'h10000 - {1'b0, cur_phase[15:0]};
	assign rem_chk   = {1'b0, y_q} - prod_q[31:0];
	assign mag_rnd   = 25'((prod_q[54:0] + 55'h2000_0000) >> 30);
	assign acc_abs   = acc_q[43] ? 44'(-acc_q) : 44'(acc_q);
	assign trial     = {rem_q, num_q[27]};
	assign t_new     = {1'b0, HORNER_COEF[cmd.coef]} - {1'b0, prod_q[60:30]};
	assign gain_mag  = prod_q[31:0];

	// one shared multiplier, operands picked by the command
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			CMD_P_INT: begin
				mul_a = {16'd0, i_q};
				mul_b = 32'(P_INT);
			end
			CMD_P_REM: begin
				mul_a = {16'd0, i_q};
				mul_b = 32'(P_REM);
			end
			CMD_Y_MUL: begin
				mul_a = {1'b0, prod_q[30:0]};
				mul_b = 32'(RECIP);
			end
			CMD_Q0_MUL: begin
				mul_a = {16'd0, prod_q[55:40]};
				mul_b = 32'(TABLE_SIZE);
			end
			CMD_UU: begin
				mul_a = {1'b0, u_q};
				mul_b = {1'b0, u_q};
			end
			CMD_H_MUL: begin
				mul_a = {1'b0, u2_q};
				mul_b = {1'b0, t_q};
			end
			CMD_S_MUL: begin
				mul_a = {1'b0, u_q};
				mul_b = {1'b0, t_q};
			end
			CMD_PK_MUL: begin
				mul_a = {1'b0, prod_q[60:30]};
				mul_b = 32'(SINE_PEAK);
			end
			CMD_W_MUL: begin
				mul_a = {9'd0, mag_q};
				mul_b = {15'd0, weight};
			end
			CMD_GAIN_MUL: begin
				mul_a = (n_q != 4'd0) ? {4'd0, num_q} : 32'd0;
				mul_b = {28'd0, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		hit   = 1'b0;
		hit_k = '0;
		for (int k = 0; k < int'(VOICES); k++) begin
			if (!hit && scan_code == KEY_CODES[k]) begin
				hit   = 1'b1;
				hit_k = 3'(k);
			end
		end
	end

	// payload work registers
	always_ff @(posedge clk) begin
		// product holds while idle so a scaled sample survives an output stall
		if (cmd.op != CMD_NONE) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		case (cmd.op)
			CMD_IDX:    i_q  <= cmd.entry ? idx_inc : idx_cur;
			CMD_P_REM:  pa_q <= prod_q[31:0];
			CMD_Y_MUL:  y_q  <= prod_q[30:0];
			CMD_Q0_MUL: q0_q <= prod_q[55:40];
			CMD_P_FIX:  p_q  <= pa_q + {16'd0, q0_q} + {31'd0, rem_chk >= 32'(TABLE_SIZE)};
			CMD_U: begin
				quad_q <= p_q[31:30];
				u_q    <= p_q[30] ? 31'h4000_0000 - {1'b0, p_q[29:0]} : {1'b0, p_q[29:0]};
			end
			CMD_H_INIT: begin
				u2_q <= prod_q[60:30];
				t_q  <= COEF_TOP;
			end
			CMD_H_SUB: t_q <= t_new[30:0];
			CMD_MAG: begin
				mag_q <= (mag_rnd > 25'(SINE_PEAK)) ? 23'(SINE_PEAK) : mag_rnd[22:0];
				neg_q <= quad_q[1];
			end
			CMD_DIV_INIT: begin
				num_q  <= acc_abs[43:16];
				dsgn_q <= acc_q[43];
				rem_q  <= '0;
				n_q    <= 4'($countones(notes_q));
			end
			CMD_DIV_STEP: begin
				if (trial >= {1'b0, n_q}) begin
					rem_q <= 4'(trial - {1'b0, n_q});
					num_q <= {num_q[26:0], 1'b1};
				end else begin
					rem_q <= trial[3:0];
					num_q <= {num_q[26:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// voice state, configuration, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				step_q[k]  <= STEP_RESET[k];
				phase_q[k] <= '0;
			end
			counter_q   <= '0;
			notes_q     <= '0;
			rel_q       <= 1'b0;
			gain_q      <= 4'd1;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			notes_out_q <= '0;
		end else begin
			if (cfg_valid) begin
				step_q[cfg_index] <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				CMD_SCAN: begin
					if (hit) begin
						notes_q[hit_k] <= !rel_q;
						rel_q          <= 1'b0;
					end else if (scan_code == BREAK_CODE) begin
						rel_q <= 1'b1;
					end else if (scan_code == VOL_UP_CODE) begin
						if (!rel_q && gain_q < 4'(MAX_VOLUME)) begin
							gain_q <= gain_q + 4'd1;
						end
						rel_q <= 1'b0;
					end else if (scan_code == VOL_DOWN_CODE) begin
						if (!rel_q && gain_q != 4'd0) begin
							gain_q <= gain_q - 4'd1;
						end
						rel_q <= 1'b0;
					end
				end
				CMD_START: acc_q <= '0;
				CMD_ACC: begin
					if (neg_q) begin
						acc_q <= acc_q - $signed({4'd0, prod_q[39:0]});
					end else begin
						acc_q <= acc_q + $signed({4'd0, prod_q[39:0]});
					end
				end
				CMD_OUT: begin
					out_valid_q <= 1'b1;
					notes_out_q <= notes_q;
					if (dsgn_q) begin
						sample_q <= (gain_mag > 32'd8388608) ? 24'sh800000 : 24'(-gain_mag);
					end else begin
						sample_q <= (gain_mag > 32'd8388607) ? 24'sh7FFFFF : 24'(gain_mag);
					end
					if (17'(counter_q) + 17'd1 >= 17'(COUNTER_WRAP)) begin
						counter_q <= '0;
						for (int k = 0; k < 8; k++) begin
							phase_q[k] <= '0;
						end
					end else begin
						counter_q <= counter_q + 16'd1;
						for (int k = 0; k < 8; k++) begin
							if ({1'b0, phase_q[k]} + {2'b0, step_q[k]} >= 33'(PHASE_MOD)) begin
								phase_q[k] <= 32'({1'b0, phase_q[k]} + {2'b0, step_q[k]}
									- 33'(PHASE_MOD));
							end else begin
								phase_q[k] <= phase_q[k] + {1'b0, step_q[k]};
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/polyphonic_wavetable_synth.sv @@
`timescale 1ns / 1ps
// a scan beat is handled as it is taken; a tick is paced by the shared multiplier stepping
// through two sine evaluations per active voice and the 28-step mix divider
// throughput: one beat at a time; the next beat is taken while a result waits on the output
// reset: arst_n clears notes, phases, counter and sets gain to one and default voice steps
// depends on pws_pkg, pws_ctrl, pws_dp
module polyphonic_wavetable_synth import pws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [7:0]         scan_code,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] sample,
	output logic [7:0]         active_notes,
	// configuration channel, one voice step per index
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// writes land directly in the step registers, so the config channel never stalls
	assign cfg_ready = 1'b1;

	// controller: sequences each tick through voices, entries and the divider
	pws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: sine by polynomial, linear interpolation, averaging and gain
	pws_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.scan_code    (scan_code),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample),
		.active_notes (active_notes)
	);

endmodule

@@ tb/polyphonic_wavetable_synth_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the eight-voice wavetable synth: keys, gain, voice steps, stalls
// depends on pws_pkg and polyphonic_wavetable_synth; carries its own model of the mix
module polyphonic_wavetable_synth_test;
	import pws_pkg::*;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 1500;
	localparam int unsigned DRAIN_CYCLES = 500;
	localparam logic [30:0] STEP_MAX = 31'd1572864000;

	typedef struct {
		logic signed [23:0] smp;
		logic [7:0]         notes;
	} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_SCAN;
	logic [7:0]         scan_code = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [23:0] sample;
	logic [7:0]         active_notes;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = 3'd0;
	logic [30:0]        cfg_data = 31'd0;

	// shadow state of the synth
	logic [30:0] voice_step [8];
	logic [31:0] voice_pos [8];
	int unsigned tick_count;
	logic [7:0]  notes_on;
	bit          break_seen;
	int unsigned gain;

	mix_t pending_mix [$];

	int unsigned errors = 0;
	int unsigned scans_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned mixes_checked = 0;
	int unsigned cfg_writes = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          hold_start = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_count = 0;

	polyphonic_wavetable_synth uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .scan_code(scan_code),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.active_notes(active_notes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sine table entry worked out from the quarter-wave polynomial
	function automatic logic signed [23:0] sine_at(int unsigned i);
		longint unsigned p, u, u2, t, s, mag;
		logic [1:0] quad;
		p = (longint'(i) << 32) / TABLE_SIZE;
		quad = p[31:30];
		u = p & 64'h3FFF_FFFF;
		if (quad[0])
			u = (64'd1 << 30) - u;
		u2 = (u * u) >> 30;
		t = COEF_TOP;
		for (int k = 0; k < 6; k++)
			t = HORNER_COEF[k] - ((u2 * t) >> 30);
		s = (u * t) >> 30;
		mag = (s * SINE_PEAK + (64'd1 << 29)) >> 30;
		if (mag > SINE_PEAK)
			mag = SINE_PEAK;
		return quad[1] ? -24'(mag) : 24'(mag);
	endfunction

	function automatic void reset_shadow();
		for (int k = 0; k < 8; k++) begin
			voice_step[k] = STEP_RESET[k];
			voice_pos[k] = '0;
		end
		tick_count = 0;
		notes_on = '0;
		break_seen = 1'b0;
		gain = 1;
	endfunction

	function automatic void apply_scan(logic [7:0] code);
		for (int k = 0; k < VOICES; k++) begin
			if (code == KEY_CODES[k]) begin
				if (break_seen) begin
					notes_on[k] = 1'b0;
					break_seen = 1'b0;
				end else begin
					notes_on[k] = 1'b1;
				end
				return;
			end
		end
		if (code == BREAK_CODE) begin
			break_seen = 1'b1;
		end else if (code == VOL_UP_CODE) begin
			if (!break_seen && gain < MAX_VOLUME)
				gain++;
			break_seen = 1'b0;
		end else if (code == VOL_DOWN_CODE) begin
			if (!break_seen && gain > 0)
				gain--;
			break_seen = 1'b0;
		end
	endfunction

	// one tick: interpolate the active voices, average, scale, clamp, then advance phases
	function automatic mix_t mix_tick();
		mix_t        m;
		longint      acc, avg;
		longint      frac;
		int unsigned idx, nxt, voices_on;
		acc = 0;
		avg = 0;
		voices_on = 0;
		for (int k = 0; k < VOICES; k++) begin
			if (notes_on[k]) begin
				idx = (voice_pos[k] >> 16) % TABLE_SIZE;
				nxt = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
				frac = longint'(voice_pos[k][15:0]);
				acc += longint'(sine_at(idx)) * (65536 - frac) + longint'(sine_at(nxt)) * frac;
				voices_on++;
			end
		end
		if (voices_on > 0)
			avg = acc / (longint'(voices_on) * 65536);
		avg = avg * longint'(gain);
		if (avg > 8388607)
			avg = 8388607;
		if (avg < -8388608)
			avg = -8388608;
		m.smp = avg[23:0];
		m.notes = notes_on;
		tick_count = (tick_count + 1) & 16'hFFFF;
		if (tick_count >= COUNTER_WRAP) begin
			tick_count = 0;
			for (int k = 0; k < 8; k++)
				voice_pos[k] = '0;
		end else begin
			for (int k = 0; k < 8; k++)
				voice_pos[k] = 32'((64'(voice_pos[k]) + voice_step[k]) % PHASE_MOD);
		end
		return m;
	endfunction

	// sends one beat; valid stays high afterwards so back-to-back beats need no drop
	task automatic send_beat(logic beat_op, logic [7:0] code);
		while (tx_idle_en && $urandom_range(99) < 19) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= beat_op;
		scan_code <= code;
		do @(posedge clk); while (!in_ready);
		if (beat_op == OP_TICK) begin
			pending_mix.push_back(mix_tick());
			ticks_sent++;
		end else begin
			apply_scan(code);
			scans_sent++;
		end
	endtask

	task automatic send_scan(logic [7:0] code);
		send_beat(OP_SCAN, code);
	endtask

	task automatic send_tick();
		send_beat(OP_TICK, 8'($urandom));
	endtask

	task automatic release_note(int k);
		send_scan(BREAK_CODE);
		send_scan(KEY_CODES[k]);
	endtask

	// config writes only with the block idle: nothing in flight and a scan beat long done
	task automatic write_step(logic [2:0] k, logic [30:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= k;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		voice_step[k] = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_idle_and_keys();
		send_tick();
		send_tick();
		for (int k = 0; k < 8; k++) begin
			send_scan(KEY_CODES[k]);
			send_tick();
		end
		// break then a note code turns only that note off
		release_note(3);
		send_tick();
		// break is kept across unrelated codes
		send_scan(BREAK_CODE);
		send_scan(8'h00);
		send_scan(8'hFF);
		send_scan(KEY_CODES[0]);
		send_tick();
		// gain up to saturation, then down to zero
		repeat (16) send_scan(VOL_UP_CODE);
		send_tick();
		repeat (17) send_scan(VOL_DOWN_CODE);
		send_tick();
		// a volume key after break only clears the break
		send_scan(BREAK_CODE);
		send_scan(VOL_UP_CODE);
		repeat (3) send_scan(VOL_UP_CODE);
		send_scan(BREAK_CODE);
		send_scan(VOL_DOWN_CODE);
		send_scan(KEY_CODES[3]);
		send_tick();
		send_tick();
	endtask

	task automatic test_step_extremes();
		for (int k = 0; k < 8; k++)
			write_step(3'(k), (k % 2 == 0) ? 31'd0 : STEP_MAX);
		for (int k = 0; k < 8; k++)
			send_scan(KEY_CODES[k]);
		repeat (6) send_tick();
		for (int k = 0; k < 8; k++)
			write_step(3'(k), STEP_RESET[k]);
		repeat (4) send_tick();
	endtask

	// well-formed key traffic with random content, some ticks, some noise, periodic step writes
	task automatic test_random_traffic(int unsigned beats);
		int unsigned pick;
		for (int n = 0; n < beats; n++) begin
			if (n == beats / 2)
				tx_idle_en = 1'b0;
			if (n == beats / 2 + 120) begin
				tx_idle_en = 1'b1;
				rx_idle_en = 1'b1;
			end
			if (n == beats / 2 + 10)
				rx_idle_en = 1'b0;
			if (n % 150 == 149)
				write_step(3'($urandom_range(7)), ($urandom_range(3) == 0) ?
					31'($urandom) : 31'($urandom_range(STEP_MAX)));
			pick = $urandom_range(99);
			if (pick < 40)
				send_tick();
			else if (pick < 60)
				send_scan(KEY_CODES[$urandom_range(7)]);
			else if (pick < 75)
				release_note($urandom_range(7));
			else if (pick < 82)
				send_scan(VOL_UP_CODE);
			else if (pick < 88)
				send_scan(VOL_DOWN_CODE);
			else if (pick < 92)
				send_scan(BREAK_CODE);
			else
				send_scan(8'($urandom));
		end
	endtask

	task automatic test_output_stall();
		hold_start = 1'b1;
		for (int k = 0; k < 8; k++)
			send_scan(KEY_CODES[k]);
		repeat (30) send_tick();
	endtask

	// receiver: random stalls, plus one long hold-off counted here
	always @(negedge clk) begin
		if (hold_start && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !rx_idle_en || ($urandom_range(99) >= 19);
		end
	end

	// result checker against the oldest expected mix
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_mix.size() == 0) begin
				$error("unexpected result beat: sample %0d notes %02h", sample, active_notes);
				errors++;
			end else begin
				mix_t m;
				m = pending_mix.pop_front();
				mixes_checked++;
				if (sample !== m.smp) begin
					$error("sample: expected %0d actual %0d", m.smp, sample);
					errors++;
				end
				if (active_notes !== m.notes) begin
					$error("active_notes: expected %02h actual %02h", m.notes, active_notes);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_mix.size());
			$display("polyphonic_wavetable_synth verification failed");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_and_keys();
		test_step_extremes();
		test_random_traffic(350);
		test_output_stall();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d scan beats, %0d ticks, %0d step writes, one long output hold",
			scans_sent, ticks_sent, cfg_writes);
		$display("%0d results checked, %0d mismatches", mixes_checked, errors);
		if (errors == 0)
			$display("polyphonic_wavetable_synth verification clean");
		else
			$display("polyphonic_wavetable_synth verification failed");
		$finish;
	end

endmodule
